FILE: design/bnpe_pkg.sv
// ----------------------------------------------------------------------------
// bnpe_pkg
// Shared types, constants and the cosine table builder for the estimator.
// ----------------------------------------------------------------------------
package bnpe_pkg;

    // fixed-point format of the three result values
    localparam int FRAC_BITS = 16;
    // default number of cosine table steps over a quarter turn
    localparam int COS_DEPTH_DEF = 1024;

    localparam logic [14:0] HALF_PI_Q14 = 15'd25736;
    localparam logic [14:0] HALF_PI_Q14_HALF = 15'd12868;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

    // reciprocal of 3217 (25736 / 8) with 40 fraction bits, exact for 28-bit dividends
    localparam logic [28:0] IDX_RECIP = 29'(((64'd1 << 40) + 64'd3216) / 64'd3217);

    // configuration register indexes
    localparam logic [1:0] REG_NEEDLE_LENGTH = 2'd0;
    localparam logic [1:0] REG_THROWS_PER_BLOCK = 2'd1;
    localparam logic [1:0] REG_NUMBER_OF_BLOCKS = 2'd2;

    // finished block handed from the front to the back
    typedef struct packed {
        logic [16:0] hits;
        logic [15:0] len;
        logic [15:0] tpb;
    } t_blk;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [17:0] divisor;
    } t_div_req;

    // reply from the shared divider
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [17:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_EST_GO,
        ST_EST_WAIT,
        ST_ACC,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_M2,
        ST_MSQ_GO,
        ST_MSQ_WAIT,
        ST_DIFF,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_ROOT,
        ST_EMIT
    } t_bk_state;

    // cosine of angle x (Q30) by a truncated Taylor series, clamped to [0, 1]
    function automatic logic [30:0] cos_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [64:0] acc;
        x2 = (x * x) >> 30;
        term = ONE_Q30;
        acc = 65'(ONE_Q30);
        term = ((term * x2) >> 30) / 64'd2;   acc = acc - 65'(term);
        term = ((term * x2) >> 30) / 64'd12;  acc = acc + 65'(term);
        term = ((term * x2) >> 30) / 64'd30;  acc = acc - 65'(term);
        term = ((term * x2) >> 30) / 64'd56;  acc = acc + 65'(term);
        term = ((term * x2) >> 30) / 64'd90;  acc = acc - 65'(term);
        term = ((term * x2) >> 30) / 64'd132; acc = acc + 65'(term);
        term = ((term * x2) >> 30) / 64'd182; acc = acc - 65'(term);
        term = ((term * x2) >> 30) / 64'd240; acc = acc + 65'(term);
        term = ((term * x2) >> 30) / 64'd306; acc = acc - 65'(term);
        term = ((term * x2) >> 30) / 64'd380; acc = acc + 65'(term);
        if (acc < 0) begin
            acc = '0;
        end
        if (acc > 65'(ONE_Q30)) begin
            acc = 65'(ONE_Q30);
        end
        return 31'(acc);
    endfunction

endpackage

FILE: design/bnpe_front.sv
// ----------------------------------------------------------------------------
// bnpe_front
// Throw pipeline: cosine lookup, hit tests, hit and throw counting, block close.
// ----------------------------------------------------------------------------
module bnpe_front
    import bnpe_pkg::*;
#(
    parameter int COS_DEPTH = COS_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_centre_position,
    input  logic [15:0] i_needle_angle,
    input  logic [15:0] i_needle_length,
    input  logic [15:0] i_throws_per_block,
    input  logic [15:0] i_number_of_blocks,
    input  logic        i_q_full,
    output logic        o_push,
    output t_blk        o_blk
);

    localparam int IW = $clog2(COS_DEPTH + 1);

    // constant cosine table, one entry per step
    logic [30:0] w_rom [COS_DEPTH + 1];
    for (genvar g = 0; g <= COS_DEPTH; g++) begin : g_rom
        localparam logic [63:0] X = (64'(g) * HALF_PI_Q30) / 64'(COS_DEPTH);
        localparam logic [30:0] ENT = cos_entry(X);
        assign w_rom[g] = ENT;
    end

    logic        en;
    logic [16:0] w_mag_raw;
    logic [14:0] w_mag;
    logic [16:0] w_q;
    logic [IW-1:0] w_idx;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5;
    logic [31:0] r_magd;
    logic [56:0] r_prod;
    logic [IW-1:0] r_idx;
    logic [30:0] r_cos;
    logic [46:0] r_h;

    logic [16:0] r_hits, n_hits;
    logic [15:0] r_tib, n_tib;
    logic [15:0] r_blocks;
    logic [47:0] w_cc;
    logic        w_rhit, w_lhit, w_live, w_close;
    logic [15:0] w_tpb;

    // whole pipeline moves only while the queue has room
    assign en = !i_q_full;
    assign o_ready = en;

    // angle magnitude, clamped to a quarter turn
    always_comb begin
        w_mag_raw = i_needle_angle[15] ? (17'h10000 - {1'b0, i_needle_angle})
                                       : {1'b0, i_needle_angle};
        w_mag = (w_mag_raw > 17'(HALF_PI_Q14)) ? HALF_PI_Q14 : w_mag_raw[14:0];
    end

    // index from the reciprocal product
    always_comb begin
        w_q = r_prod[56:40];
        w_idx = (w_q > 17'(COS_DEPTH)) ? IW'(COS_DEPTH) : IW'(w_q);
    end

    // control of pipeline stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= i_centre_position;
            r_magd <= 32'(w_mag) * 32'(COS_DEPTH) + 32'(HALF_PI_Q14_HALF);
            r_c2 <= r_c1;
            r_prod <= 57'(r_magd[30:3]) * 57'(IDX_RECIP);
            r_c3 <= r_c2;
            r_idx <= w_idx;
            r_c4 <= r_c3;
            r_cos <= w_rom[r_idx];
            r_c5 <= r_c4;
            r_h <= 47'(r_cos) * 47'(i_needle_length);
        end
    end

    // hit tests and block close
    always_comb begin
        w_cc = {1'b0, r_c5, 31'd0};
        w_rhit = (w_cc + 48'(r_h)) > (48'd1 << 47);
        w_lhit = w_cc < 48'(r_h);
        w_live = r_v5 && en && (r_blocks < i_number_of_blocks);
        w_tpb = (i_throws_per_block == '0) ? 16'd1 : i_throws_per_block;
        n_hits = r_hits + 17'(w_rhit) + 17'(w_lhit);
        n_tib = r_tib + 16'd1;
        w_close = w_live && (n_tib >= w_tpb);
    end

    // block counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_tib <= '0;
            r_blocks <= '0;
        end else if (w_close) begin
            r_hits <= '0;
            r_tib <= '0;
            r_blocks <= r_blocks + 16'd1;
        end else if (w_live) begin
            r_hits <= n_hits;
            r_tib <= n_tib;
        end
    end

    assign o_push = w_close;
    assign o_blk = '{hits: n_hits, len: i_needle_length, tpb: w_tpb};

endmodule

FILE: design/bnpe_fifo.sv
// ----------------------------------------------------------------------------
// bnpe_fifo
// Short queue of finished blocks between the front and the back.
// ----------------------------------------------------------------------------
module bnpe_fifo
    import bnpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_blk i_blk,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_blk o_blk
);

    t_blk       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full = r_cnt[2];
    assign o_empty = (r_cnt == '0);
    assign o_blk = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_blk;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

endmodule

FILE: design/bnpe_div.sv
// ----------------------------------------------------------------------------
// bnpe_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bnpe_div
    import bnpe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [17:0] r_rem;
    logic [17:0] r_div;
    logic [18:0] w_sh;
    logic        w_ge;

    // one trial subtraction
    always_comb begin
        w_sh = {r_rem, r_q[63]};
        w_ge = w_sh >= {1'b0, r_div};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? 18'(w_sh - {1'b0, r_div}) : w_sh[17:0];
        end
    end

    assign o_rsp = '{done: r_done, quot: r_q, rem: r_rem};

endmodule

FILE: design/bnpe_back.sv
// ----------------------------------------------------------------------------
// bnpe_back
// Block statistics sequencer: estimate, running mean, blocking error, output.
// ----------------------------------------------------------------------------
module bnpe_back
    import bnpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_blk        i_blk,
    output logic        o_pop,
    output t_div_req    o_div_req,
    input  t_div_rsp    i_div_rsp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_block_estimate,
    output logic [23:0] o_running_mean,
    output logic [23:0] o_running_error,
    output logic [15:0] o_block_number,
    output logic        o_no_hits
);

    t_bk_state   r_state, n_state;
    t_blk        r_blk;
    logic [31:0] r_prod;
    logic [23:0] r_est, r_mean, r_err;
    logic        r_flag;
    logic [47:0] r_estsq, r_m2;
    logic [39:0] r_sum;
    logic [63:0] r_sq, r_msq, r_diff;
    logic [15:0] r_n;
    logic [63:0] r_rv, r_res, r_bit;
    logic [4:0]  r_rcnt;
    logic        r_ov;
    logic [63:0] w_rtry;
    logic        w_rge;
    logic        w_emit;
    logic [17:0] w_half;

    // one square root step
    always_comb begin
        w_rtry = r_res + r_bit;
        w_rge = r_rv >= w_rtry;
        w_half = 18'(r_n - (r_n >> 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (!i_q_empty) n_state = ST_PROD;
            ST_PROD:      n_state = (r_blk.hits == '0) ? ST_ACC : ST_EST_GO;
            ST_EST_GO:    n_state = ST_EST_WAIT;
            ST_EST_WAIT:  if (i_div_rsp.done) n_state = ST_ACC;
            ST_ACC:       n_state = ST_MEAN_GO;
            ST_MEAN_GO:   n_state = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (i_div_rsp.done) n_state = (r_n > 16'd1) ? ST_M2 : ST_EMIT;
            ST_M2:        n_state = ST_MSQ_GO;
            ST_MSQ_GO:    n_state = ST_MSQ_WAIT;
            ST_MSQ_WAIT:  if (i_div_rsp.done) n_state = ST_DIFF;
            ST_DIFF:      n_state = ST_VAR_GO;
            ST_VAR_GO:    n_state = ST_VAR_WAIT;
            ST_VAR_WAIT:  if (i_div_rsp.done) n_state = ST_ROOT;
            ST_ROOT:      if (r_rcnt == 5'd31) n_state = ST_EMIT;
            ST_EMIT:      if (!r_ov || i_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs: queue pop, divider requests and result emit
    always_comb begin
        o_pop = 1'b0;
        w_emit = 1'b0;
        o_div_req = '{start: 1'b0, dividend: '0, divisor: '0};
        unique case (r_state)
            ST_IDLE: o_pop = !i_q_empty;
            ST_EST_GO: o_div_req = '{start: 1'b1,
                                     dividend: {30'd0, r_prod, 2'b00} + 64'(r_blk.hits),
                                     divisor: {r_blk.hits, 1'b0}};
            ST_MEAN_GO: o_div_req = '{start: 1'b1,
                                      dividend: 64'(r_sum) + 64'(r_n >> 1),
                                      divisor: 18'(r_n)};
            ST_MSQ_GO: o_div_req = '{start: 1'b1, dividend: r_sq, divisor: 18'(r_n)};
            ST_VAR_GO: o_div_req = '{start: 1'b1,
                                     dividend: r_diff + 64'((r_n - 16'd1) >> 1),
                                     divisor: 18'(r_n - 16'd1)};
            ST_EMIT: w_emit = !r_ov || i_ready;
            default: o_pop = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
            r_n <= '0;
            r_sum <= '0;
            r_sq <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == ST_ACC) begin
                r_n <= r_n + 16'd1;
                r_sum <= r_sum + 40'(r_est);
            end
            if (r_state == ST_MEAN_GO) begin
                r_sq <= r_sq + 64'(r_estsq);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: r_blk <= i_blk;
            ST_PROD: begin
                r_prod <= 32'(r_blk.len) * 32'(r_blk.tpb);
                r_flag <= (r_blk.hits == '0);
                r_est <= OUT_MAX;
            end
            ST_EST_WAIT: if (i_div_rsp.done) begin
                r_est <= (i_div_rsp.quot > 64'(OUT_MAX)) ? OUT_MAX : i_div_rsp.quot[23:0];
            end
            ST_ACC: r_estsq <= 48'(r_est) * 48'(r_est);
            ST_MEAN_WAIT: if (i_div_rsp.done) begin
                r_mean <= (i_div_rsp.quot > 64'(OUT_MAX)) ? OUT_MAX : i_div_rsp.quot[23:0];
                r_err <= '0;
            end
            ST_M2: r_m2 <= 48'(r_mean) * 48'(r_mean);
            ST_MSQ_WAIT: if (i_div_rsp.done) begin
                r_msq <= i_div_rsp.quot + 64'(i_div_rsp.rem >= w_half);
            end
            ST_DIFF: r_diff <= (r_msq > 64'(r_m2)) ? r_msq - 64'(r_m2) : '0;
            ST_VAR_WAIT: if (i_div_rsp.done) begin
                r_rv <= i_div_rsp.quot;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_rcnt <= '0;
            end
            ST_ROOT: begin
                if (w_rge) begin
                    r_rv <= r_rv - w_rtry;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_rcnt <= r_rcnt + 5'd1;
            end
            ST_EMIT: r_err <= (r_res > 64'(OUT_MAX)) ? r_err : r_err;
            default: r_rcnt <= r_rcnt;
        endcase
        if (r_state == ST_ROOT && r_rcnt == 5'd31) begin
            if (w_rge) begin
                r_err <= (((r_res >> 1) + r_bit) > 64'(OUT_MAX)) ? OUT_MAX
                         : 24'((r_res >> 1) + r_bit);
            end else begin
                r_err <= ((r_res >> 1) > 64'(OUT_MAX)) ? OUT_MAX : 24'(r_res >> 1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_block_estimate <= r_est;
            o_running_mean <= r_mean;
            o_running_error <= r_err;
            o_block_number <= r_n;
            o_no_hits <= r_flag;
        end
    end

    assign o_valid = r_ov;

endmodule

FILE: design/buffon_needle_pi_block_estimator_core.sv
// ----------------------------------------------------------------------------
// buffon_needle_pi_block_estimator_core
// Buffon needle pi estimator with blocking statistics.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one needle throw per transfer, tdata = {angle, centre}.
//   m_axis gives one transfer per finished block: estimate, running mean,
//   blocking error and block number in tdata, the zero-hit flag in tuser.
//   The cfg channel writes needle length, throws per block and block count;
//   it is always ready. The user must write it only while the block is
//   idle; the block itself does not enforce this.
// Flow:
//   a throw is taken every cycle, the front stalling only when the queue is
//   full; its hit test follows the magnitude, product, index, cosine and
//   height registers. A finished block is queued (four entries); the back
//   sequencer takes one block at a time, with up to four shared divider
//   passes and, from the second block on, 32 square root steps.
// Reset clears the throw, hit, block, queue and divider counters and the sums, and loads the register defaults.
// A stalled receiver holds the result in the output register; the back
// then waits and the queue fills before throws are refused.
// ----------------------------------------------------------------------------
module buffon_needle_pi_block_estimator_core
    import bnpe_pkg::*;
#(
    parameter int COS_DEPTH = COS_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // centre_position[15:0], needle_angle[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // block_estimate[23:0], running_mean[47:24], running_error[71:48],
    // block_number[87:72]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tuser,   // no_hits[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_len, r_tpb, r_nblk;
    logic        w_push, w_full, w_pop, w_empty;
    t_blk        w_blk_in, w_blk_out;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 16'd52429;
            r_tpb <= 16'd1000;
            r_nblk <= 16'd100;
        end else if (i_cfg_valid) begin
            priority if (i_cfg_index == REG_NEEDLE_LENGTH) r_len <= i_cfg_data;
            else if (i_cfg_index == REG_THROWS_PER_BLOCK) r_tpb <= i_cfg_data;
            else if (i_cfg_index == REG_NUMBER_OF_BLOCKS) r_nblk <= i_cfg_data;
            else r_len <= r_len;
        end
    end

    bnpe_front #(.COS_DEPTH(COS_DEPTH)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_centre_position (s_axis_tdata[15:0]),
        .i_needle_angle    (s_axis_tdata[31:16]),
        .i_needle_length   (r_len),
        .i_throws_per_block(r_tpb),
        .i_number_of_blocks(r_nblk),
        .i_q_full          (w_full),
        .o_push            (w_push),
        .o_blk             (w_blk_in)
    );

    bnpe_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_blk  (w_blk_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_blk  (w_blk_out)
    );

    bnpe_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    bnpe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_empty),
        .i_blk           (w_blk_out),
        .o_pop           (w_pop),
        .o_div_req       (w_req),
        .i_div_rsp       (w_rsp),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_block_estimate(m_axis_tdata[23:0]),
        .o_running_mean  (m_axis_tdata[47:24]),
        .o_running_error (m_axis_tdata[71:48]),
        .o_block_number  (m_axis_tdata[87:72]),
        .o_no_hits       (m_axis_tuser)
    );

endmodule

FILE: design/bnpe_checker.sv
// ----------------------------------------------------------------------------
// bnpe_checker
// Port-level checks on the result stream of the estimator.
// ----------------------------------------------------------------------------
module bnpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // zero-hit block reports a saturated estimate
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:0] == 24'hFFFFFF)
        else $error("no_hits without saturated estimate");

    // first block carries no error
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[87:72] == 16'd1 |-> m_axis_tdata[71:48] == 24'd0)
        else $error("nonzero error on first block");

    // nothing shown right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind buffon_needle_pi_block_estimator_core bnpe_checker u_bnpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
